// File: hdl/chained_hash_join_table_assert.svh
// Assertion macros for the chained hash-join table.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef CHAINED_HASH_JOIN_TABLE_ASSERT_SVH
`define CHAINED_HASH_JOIN_TABLE_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define CHJT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define CHJT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: hdl/chjt_pkg.sv
// Package for the chained hash-join table: sizes, codes and shared types.
// It has no dependencies.
`default_nettype none
package chjt_pkg;
	localparam int HEAD_LOG2   = 10;
	localparam int NHEAD       = 1 << HEAD_LOG2;
	localparam int POOL_BKTS   = 1024;
	localparam int NBKT        = NHEAD + POOL_BKTS;
	localparam int BKT_W       = $clog2(NBKT);
	localparam int LINK_W      = $clog2(NBKT + 1);
	localparam int TUPLES      = 2;
	localparam int SLOT_W      = $clog2(TUPLES);
	localparam int FILL_W      = $clog2(TUPLES + 1);
	localparam int SLOT_AW     = BKT_W + SLOT_W;
	localparam int POOL_W      = $clog2(POOL_BKTS + 1);
	localparam int MAX_RES     = 64;
	localparam int CNT_W       = $clog2(MAX_RES + 1);
	localparam int IBITS_W     = 4;
	localparam int SKIP_W      = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_PROBE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_BITS  = 1'd1;

	typedef struct packed {
		logic [LINK_W-1:0] link;
		logic [FILL_W-1:0] fill;
	} meta_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_INS_HEAD,
		ST_INS_NEXT,
		ST_INS_LINK,
		ST_PRB_META,
		ST_PRB_SLOT,
		ST_PRB_END
	} state_t;
endpackage
`default_nettype wire

// File: hdl/chained_hash_join_table.sv
// Chained hash-join table engine: sequencer, bucket metadata memory and slot memory.
// Depends on chjt_pkg and chained_hash_join_table_assert.svh.
//
// A command word is taken when start is high and busy is low. Results come out one per
// cycle on strobe and cannot be held off. Insert reads the head bucket, then a second
// bucket when the head bucket is full and links to one, and links in a pool bucket, if
// one is free, when no bucket read has room. Probe reads each bucket's metadata and then
// its tuples one at a time, and goes to its final result when a bucket it reads is empty;
// its pace is set by the one-read-port metadata and slot memories and the single key
// comparator. Clear gives no result and runs a sweep of the head buckets; the same sweep
// follows reset, and busy stays high during it.
`default_nettype none
`include "chained_hash_join_table_assert.svh"
module chained_hash_join_table
	import chjt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            cmd,
	input  wire logic [31:0]           key,
	input  wire logic [31:0]           payload,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output logic                       strobe,
	output logic                       status,
	output logic                       matched,
	output logic [31:0]                build_payload,
	output logic [31:0]                probe_payload,
	output logic                       truncated,
	output logic                       last
);
	state_t state_q, state_d;

	logic [IBITS_W-1:0]   ibits_q;
	logic [SKIP_W-1:0]    skip_q;
	logic [HEAD_LOG2-1:0] sweep_q;
	logic [31:0]          key_q, pay_q, pend_q;
	logic [BKT_W-1:0]     bkt_q;
	logic [HEAD_LOG2-1:0] head_q;
	logic [FILL_W-1:0]    fill_q;
	logic [LINK_W-1:0]    link_q, nxt_q;
	logic [SLOT_W-1:0]    j_q;
	logic [CNT_W-1:0]     n_q;
	logic                 drop_q;
	logic [POOL_W-1:0]    pool_q;

	logic                 strobe_q, status_q, matched_q, trunc_q, last_q;
	logic [31:0]          build_q, probe_q;

	meta_t                meta_mem [NBKT];
	logic [63:0]          slot_mem [1 << SLOT_AW];
	meta_t                meta_rd_q;
	logic [63:0]          slot_rd_q;

	meta_t                meta_wdata;
	logic                 meta_we, slot_we;
	logic [BKT_W-1:0]     meta_waddr, meta_raddr;
	logic [SLOT_AW-1:0]   slot_waddr, slot_raddr;

	logic                 emit, emit_status, emit_matched, emit_trunc, emit_last;
	logic [31:0]          emit_build;

	logic [IBITS_W-1:0]   ibits_sat;
	logic [31:0]          key_shift;
	logic [HEAD_LOG2-1:0] head_idx;
	logic                 is_match, has_room, pool_full, more_slots;
	logic [LINK_W-1:0]    alloc_nxt;
	logic [BKT_W-1:0]     new_bkt;

	assign ibits_sat = (ibits_q > IBITS_W'(HEAD_LOG2)) ? IBITS_W'(HEAD_LOG2) : ibits_q;
	assign key_shift = key >> skip_q;
	assign head_idx  = key_shift[HEAD_LOG2-1:0] & ~({HEAD_LOG2{1'b1}} << ibits_sat);

	assign is_match   = (slot_rd_q[63:32] == key_q);
	assign has_room   = (meta_rd_q.fill < FILL_W'(TUPLES));
	assign pool_full  = (pool_q >= POOL_W'(POOL_BKTS));
	assign more_slots = ((FILL_W'(j_q) + FILL_W'(1)) < fill_q);
	assign alloc_nxt  = (state_q == ST_INS_HEAD) ? meta_rd_q.link : nxt_q;
	assign new_bkt    = BKT_W'(NHEAD) + BKT_W'(pool_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		meta_we      = 1'b0;
		meta_waddr   = bkt_q;
		meta_wdata   = '0;
		meta_raddr   = bkt_q;
		slot_we      = 1'b0;
		slot_waddr   = {bkt_q, meta_rd_q.fill[SLOT_W-1:0]};
		slot_raddr   = {bkt_q, j_q};
		emit         = 1'b0;
		emit_status  = 1'b0;
		emit_matched = 1'b0;
		emit_build   = '0;
		emit_trunc   = 1'b0;
		emit_last    = 1'b0;
		unique case (state_q)
			ST_SWEEP: begin
				meta_we    = 1'b1;
				meta_waddr = BKT_W'(sweep_q);
				if (sweep_q == {HEAD_LOG2{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				meta_raddr = BKT_W'(head_idx);
				if (start) begin
					priority case (cmd)
						CMD_CLEAR:  state_d = ST_SWEEP;
						CMD_INSERT: state_d = ST_INS_HEAD;
						CMD_PROBE:  state_d = ST_PRB_META;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_INS_HEAD, ST_INS_NEXT: begin
				if (has_room) begin
					slot_we         = 1'b1;
					meta_we         = 1'b1;
					meta_wdata.link = meta_rd_q.link;
					meta_wdata.fill = meta_rd_q.fill + FILL_W'(1);
					emit            = 1'b1;
					emit_last       = 1'b1;
					state_d         = ST_IDLE;
				end else if (state_q == ST_INS_HEAD && meta_rd_q.link != '0) begin
					meta_raddr = BKT_W'(meta_rd_q.link - LINK_W'(1));
					state_d    = ST_INS_NEXT;
				end else if (pool_full) begin
					emit        = 1'b1;
					emit_status = 1'b1;
					emit_last   = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					// Take the next pool bucket; the head's link is rewritten next cycle.
					meta_we         = 1'b1;
					meta_waddr      = new_bkt;
					meta_wdata.link = alloc_nxt;
					meta_wdata.fill = FILL_W'(1);
					slot_we         = 1'b1;
					slot_waddr      = {new_bkt, SLOT_W'(0)};
					state_d         = ST_INS_LINK;
				end
			end
			ST_INS_LINK: begin
				meta_we         = 1'b1;
				meta_waddr      = BKT_W'(head_q);
				meta_wdata.link = link_q;
				meta_wdata.fill = FILL_W'(TUPLES);
				emit            = 1'b1;
				emit_last       = 1'b1;
				state_d         = ST_IDLE;
			end
			ST_PRB_META: begin
				slot_raddr = {bkt_q, SLOT_W'(0)};
				state_d    = (meta_rd_q.fill == '0) ? ST_PRB_END : ST_PRB_SLOT;
			end
			ST_PRB_SLOT: begin
				// A match is held back one step so the final one can carry last.
				if (is_match && n_q < CNT_W'(MAX_RES) && n_q != '0) begin
					emit         = 1'b1;
					emit_matched = 1'b1;
					emit_build   = pend_q;
				end
				if (more_slots) begin
					slot_raddr = {bkt_q, j_q + SLOT_W'(1)};
				end else if (link_q != '0) begin
					meta_raddr = BKT_W'(link_q - LINK_W'(1));
					state_d    = ST_PRB_META;
				end else begin
					state_d = ST_PRB_END;
				end
			end
			ST_PRB_END: begin
				emit         = 1'b1;
				emit_last    = 1'b1;
				emit_matched = (n_q != '0);
				emit_build   = (n_q != '0) ? pend_q : '0;
				emit_trunc   = drop_q;
				state_d      = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		meta_rd_q <= meta_mem[meta_raddr];
		if (slot_we) begin
			slot_mem[slot_waddr] <= {key_q, pay_q};
		end
		slot_rd_q <= slot_mem[slot_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibits_q <= IBITS_W'(HEAD_LOG2);
			skip_q  <= '0;
			sweep_q <= '0;
			pool_q  <= '0;
			n_q     <= '0;
			drop_q  <= 1'b0;
		end else begin
			if (wr_en && wr_index == REG_INDEX_BITS) begin
				ibits_q <= wr_data[IBITS_W-1:0];
			end
			if (wr_en && wr_index == REG_SKIP_BITS) begin
				skip_q <= wr_data[SKIP_W-1:0];
			end
			if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + HEAD_LOG2'(1);
			end
			if (state_q == ST_IDLE && start && cmd == CMD_CLEAR) begin
				sweep_q <= '0;
				pool_q  <= '0;
			end
			if (state_q == ST_IDLE && start && cmd == CMD_PROBE) begin
				n_q    <= '0;
				drop_q <= 1'b0;
			end
			if ((state_q == ST_INS_HEAD || state_q == ST_INS_NEXT) && state_d == ST_INS_LINK) begin
				pool_q <= pool_q + POOL_W'(1);
			end
			if (state_q == ST_PRB_SLOT && is_match) begin
				if (n_q < CNT_W'(MAX_RES)) begin
					n_q <= n_q + CNT_W'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				key_q  <= key;
				pay_q  <= payload;
				head_q <= head_idx;
				bkt_q  <= BKT_W'(head_idx);
			end
			ST_INS_HEAD: begin
				nxt_q  <= meta_rd_q.link;
				link_q <= LINK_W'(new_bkt) + LINK_W'(1);
				if (meta_rd_q.link != '0) begin
					bkt_q <= BKT_W'(meta_rd_q.link - LINK_W'(1));
				end
			end
			ST_INS_NEXT: begin
				link_q <= LINK_W'(new_bkt) + LINK_W'(1);
			end
			ST_PRB_META: begin
				fill_q <= meta_rd_q.fill;
				link_q <= meta_rd_q.link;
				j_q    <= '0;
			end
			ST_PRB_SLOT: begin
				if (is_match && n_q < CNT_W'(MAX_RES)) begin
					pend_q <= slot_rd_q[31:0];
				end
				if (more_slots) begin
					j_q <= j_q + SLOT_W'(1);
				end else if (link_q != '0) begin
					bkt_q <= BKT_W'(link_q - LINK_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q  <= emit_status;
			matched_q <= emit_matched;
			build_q   <= emit_build;
			probe_q   <= (state_q == ST_PRB_SLOT || state_q == ST_PRB_END) ? pay_q : '0;
			trunc_q   <= emit_trunc;
			last_q    <= emit_last;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign strobe        = strobe_q;
	assign status        = status_q;
	assign matched       = matched_q;
	assign build_payload = build_q;
	assign probe_payload = probe_q;
	assign truncated     = trunc_q;
	assign last          = last_q;

	`CHJT_ASSERT(a_strobe_from_work, strobe |-> $past(busy), "result word without a command in progress")
	`CHJT_NEVER(a_match_count, n_q > CNT_W'(MAX_RES), "probe match count beyond the limit")
	`CHJT_NEVER(a_pool_bound, pool_q > POOL_W'(POOL_BKTS), "pool allocation beyond its size")
	`CHJT_ASSERT(a_sweep_silent, (state_q == ST_SWEEP) |=> !strobe, "result word during table sweep")
endmodule
`default_nettype wire
